@@ rtl/i2a_pkg.sv @@
// Shared types, constants, microcode and helpers for the int64 to ASCII converter.
package i2a_pkg;

  localparam int unsigned ValW      = 64;
  localparam int unsigned NumDigits = 20;
  localparam int unsigned DigW      = 4 * NumDigits;
  localparam int unsigned CntW      = $clog2(NumDigits + 1);
  localparam int unsigned BitCntW   = $clog2(ValW);
  localparam int unsigned UpcW      = 4;

  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharNone  = 8'h00;

  typedef logic [UpcW-1:0] upc_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_INIT,
    OP_DABBLE,
    OP_SKIP,
    OP_SIGN,
    OP_DIGIT,
    OP_STATUS
  } op_e;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NO_ACCEPT,
    C_SPECIAL,
    C_HEX,
    C_BITS_LEFT,
    C_LEAD_ZERO,
    C_OUT_BUSY,
    C_DIGITS_LEFT
  } cond_e;

  typedef enum logic [1:0] {
    ST_TEXT    = 2'd0,
    ST_NA      = 2'd1,
    ST_NEG_HEX = 2'd2
  } status_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    upc_t  target;
  } uinstr_t;

  // Program addresses
  localparam upc_t UpcIdle   = 4'd0;
  localparam upc_t UpcCheck  = 4'd1;
  localparam upc_t UpcInit   = 4'd2;
  localparam upc_t UpcDabble = 4'd3;
  localparam upc_t UpcSkip   = 4'd4;
  localparam upc_t UpcSign   = 4'd5;
  localparam upc_t UpcDigit  = 4'd6;
  localparam upc_t UpcDone   = 4'd7;
  localparam upc_t UpcStatus = 4'd8;
  localparam upc_t UpcRet    = 4'd9;

  // Control store: jump to target when the condition holds, else step on.
  function automatic uinstr_t ucode(upc_t pc);
    uinstr_t w;
    case (pc)
      UpcIdle:   w = '{op: OP_LOAD,   cond: C_NO_ACCEPT,   target: UpcIdle};
      UpcCheck:  w = '{op: OP_NOP,    cond: C_SPECIAL,     target: UpcStatus};
      UpcInit:   w = '{op: OP_INIT,   cond: C_HEX,         target: UpcSkip};
      UpcDabble: w = '{op: OP_DABBLE, cond: C_BITS_LEFT,   target: UpcDabble};
      UpcSkip:   w = '{op: OP_SKIP,   cond: C_LEAD_ZERO,   target: UpcSkip};
      UpcSign:   w = '{op: OP_SIGN,   cond: C_OUT_BUSY,    target: UpcSign};
      UpcDigit:  w = '{op: OP_DIGIT,  cond: C_DIGITS_LEFT, target: UpcDigit};
      UpcDone:   w = '{op: OP_NOP,    cond: C_ALWAYS,      target: UpcIdle};
      UpcStatus: w = '{op: OP_STATUS, cond: C_OUT_BUSY,    target: UpcStatus};
      UpcRet:    w = '{op: OP_NOP,    cond: C_ALWAYS,      target: UpcIdle};
      default:   w = '{op: OP_NOP,    cond: C_ALWAYS,      target: UpcIdle};
    endcase
    return w;
  endfunction

  // Lower-case hex / decimal digit to ASCII
  function automatic logic [7:0] digit_char(logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = 8'h30 + {4'h0, d};
    end else begin
      c = 8'h57 + {4'h0, d};
    end
    return c;
  endfunction

endpackage

@@ rtl/i2a_in_if.sv @@
// Input channel: one value and a base select per beat.
interface i2a_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic        base_hex;

  modport source (output valid, output value, output base_hex, input ready);
  modport sink   (input valid, input value, input base_hex, output ready);
endinterface

@@ rtl/i2a_out_if.sv @@
// Output channel: one character or status result per beat.
interface i2a_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;
  logic [1:0] status;

  modport source (output valid, output char_code, output last, output status, input ready);
  modport sink   (input valid, input char_code, input last, input status, output ready);
endinterface

@@ rtl/int64_to_ascii_digits_top.sv @@
// Signed 64-bit to ASCII text converter, decimal or lower-case hex.
//
// One value is taken at a time and its text comes out one character per beat,
// most significant digit first, with last set on the final character. A value
// equal to na_code gives a single NA status beat; a negative value in hex mode
// gives a single error status beat. A small microprogram steps the datapath:
// after the load, check and init steps, decimal conversion runs the
// shift-and-add-3 loop with one step per input bit (hex skips the loop),
// then one step per suppressed leading zero plus one to find the first
// digit, the sign step, one emit step per digit and a return step. An NA or
// error status item runs the load, check, status and return steps. The sign,
// emit and status steps wait while the output stalls. The result register
// lets the next value be loaded while the final beat still waits to be taken.
module int64_to_ascii_digits_top
  import i2a_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic signed [ValW-1:0] cfg_wdata_i,
  i2a_in_if.sink                 in_i,
  i2a_out_if.source              out_o
);

  logic [ValW-1:0]    na_code_q;
  upc_t               pc_q, pc_d;
  uinstr_t            uw;
  logic               cond_true;

  logic [ValW-1:0]    mag_q, mag_d;
  logic [DigW-1:0]    digits_q, digits_d, digits_adj;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [BitCntW-1:0] bitcnt_q, bitcnt_d;
  logic               neg_q, neg_d;
  logic               hex_q, hex_d;
  logic               na_q, na_d;

  logic               out_valid_q, out_valid_d;
  logic [7:0]         char_q, char_d;
  logic               last_q, last_d;
  status_e            status_q, status_d;

  logic               slot_free;
  logic               accept;
  logic               lead_zero;
  logic               in_neg;

  assign uw        = ucode(pc_q);
  assign slot_free = !out_valid_q || out_o.ready;
  assign accept    = in_i.valid && in_i.ready;
  assign lead_zero = (digits_q[DigW-1 -: 4] == 4'd0) && (cnt_q != CntW'(1));
  assign in_neg    = in_i.value[ValW-1];

  assign in_i.ready      = (pc_q == UpcIdle);
  assign out_o.valid     = out_valid_q;
  assign out_o.char_code = char_q;
  assign out_o.last      = last_q;
  assign out_o.status    = status_q;

  // Add 3 to every BCD digit of five or more before the shift
  always_comb begin
    digits_adj = digits_q;
    for (int i = 0; i < NumDigits; i++) begin
      if (digits_q[4*i +: 4] >= 4'd5) begin
        digits_adj[4*i +: 4] = digits_q[4*i +: 4] + 4'd3;
      end
    end
  end

  always_comb begin
    case (uw.cond)
      C_ALWAYS:      cond_true = 1'b1;
      C_NO_ACCEPT:   cond_true = !accept;
      C_SPECIAL:     cond_true = na_q || (hex_q && neg_q);
      C_HEX:         cond_true = hex_q;
      C_BITS_LEFT:   cond_true = (bitcnt_q != '0);
      C_LEAD_ZERO:   cond_true = lead_zero;
      C_OUT_BUSY:    cond_true = !slot_free;
      C_DIGITS_LEFT: cond_true = !slot_free || (cnt_q != CntW'(1));
      default:       cond_true = 1'b1;
    endcase
    pc_d = cond_true ? uw.target : pc_q + upc_t'(1);
  end

  always_comb begin
    mag_d       = mag_q;
    digits_d    = digits_q;
    cnt_d       = cnt_q;
    bitcnt_d    = bitcnt_q;
    neg_d       = neg_q;
    hex_d       = hex_q;
    na_d        = na_q;
    out_valid_d = out_valid_q && !out_o.ready;
    char_d      = char_q;
    last_d      = last_q;
    status_d    = status_q;

    unique case (uw.op)
      OP_NOP: begin
      end
      OP_LOAD: begin
        if (accept) begin
          neg_d = in_neg;
          hex_d = in_i.base_hex;
          na_d  = (in_i.value == na_code_q);
          mag_d = in_neg ? (~in_i.value + ValW'(1)) : in_i.value;
        end
      end
      OP_INIT: begin
        digits_d = hex_q ? {{(DigW-ValW){1'b0}}, mag_q} : '0;
        cnt_d    = CntW'(NumDigits);
        bitcnt_d = '1;
      end
      OP_DABBLE: begin
        digits_d = {digits_adj[DigW-2:0], mag_q[ValW-1]};
        mag_d    = {mag_q[ValW-2:0], 1'b0};
        bitcnt_d = bitcnt_q - BitCntW'(1);
      end
      OP_SKIP: begin
        if (lead_zero) begin
          digits_d = {digits_q[DigW-5:0], 4'd0};
          cnt_d    = cnt_q - CntW'(1);
        end
      end
      OP_SIGN: begin
        if (slot_free && neg_q && !hex_q) begin
          out_valid_d = 1'b1;
          char_d      = CharMinus;
          last_d      = 1'b0;
          status_d    = ST_TEXT;
        end
      end
      OP_DIGIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          char_d      = digit_char(digits_q[DigW-1 -: 4]);
          last_d      = (cnt_q == CntW'(1));
          status_d    = ST_TEXT;
          digits_d    = {digits_q[DigW-5:0], 4'd0};
          cnt_d       = cnt_q - CntW'(1);
        end
      end
      OP_STATUS: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          char_d      = CharNone;
          last_d      = 1'b1;
          status_d    = na_q ? ST_NA : ST_NEG_HEX;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= UpcIdle;
      out_valid_q <= 1'b0;
      na_code_q   <= {1'b1, {(ValW-1){1'b0}}};
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        na_code_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q    <= mag_d;
    digits_q <= digits_d;
    cnt_q    <= cnt_d;
    bitcnt_q <= bitcnt_d;
    neg_q    <= neg_d;
    hex_q    <= hex_d;
    na_q     <= na_d;
    char_q   <= char_d;
    last_q   <= last_d;
    status_q <= status_d;
  end

  // A new beat is only ever loaded by one of the emitting steps
  a_beat_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(pc_q) == UpcSign || $past(pc_q) == UpcDigit ||
                            $past(pc_q) == UpcStatus))
    else $error("output beat loaded outside an emit step");

  // A status beat is a single, final beat with no character
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != ST_TEXT) |-> (last_q && char_q == CharNone))
    else $error("status beat not marked last or carries a character");

  // Digit emission never runs out of digits
  a_digit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == UpcDigit) |-> (cnt_q != '0))
    else $error("digit counter underflow");

endmodule
